### src/tsp_pkg.sv
// Package for the turnout servo position decoder.
// Holds the item structs, command and register codes and the shared constants.
// No dependencies; every other file of the block refers to it by scoped names.
package tsp_pkg;

    // Number of servo channels in use, and the fixed number of table slots.
    localparam int SERVO_CHANNELS = 16;
    localparam int NUM_SLOTS      = 16;

    // Angle limits in degrees.
    localparam logic [7:0]        ANGLE_MAX = 8'd180;
    localparam logic signed [7:0] REL_MIN   = -8'sd90;
    localparam logic signed [7:0] REL_MAX   = 8'sd90;

    // Division by 180 as a multiplication by a rounded-up reciprocal.
    // The result is exact for every dividend below 2**20.
    localparam logic [20:0] RECIP_MULT  = 21'd1491309;
    localparam int          RECIP_SHIFT = 28;

    // Input item commands.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_BUS     = 3'd1;
    localparam logic [2:0] CMD_TEST    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_STARTUP = 3'd4;

    // Test move actions.
    localparam logic [7:0] ACT_CENTRE   = 8'd2;
    localparam logic [7:0] ACT_STRAIGHT = 8'd3;
    localparam logic [7:0] ACT_DIVERGE  = 8'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_USE_GROUP_A  = 3'd0;
    localparam logic [2:0] CFG_USE_GROUP_B  = 3'd1;
    localparam logic [2:0] CFG_RELAX_ENABLE = 3'd2;
    localparam logic [2:0] CFG_RELAX_TICKS  = 3'd3;
    localparam logic [2:0] CFG_MIN_PULSE    = 3'd4;
    localparam logic [2:0] CFG_MAX_PULSE    = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RELAX_TICKS_RST = 16'd700;
    localparam logic [11:0] MIN_PULSE_RST   = 12'd110;
    localparam logic [11:0] MAX_PULSE_RST   = 12'd500;

    // Servo table reset values.
    localparam logic [7:0]        ZERO_RST = 8'd90;
    localparam logic signed [7:0] LO_RST   = -8'sd40;
    localparam logic signed [7:0] HI_RST   = 8'sd40;

    // One input item.
    typedef struct packed {
        logic [2:0]        command;
        logic [7:0]        data_a;
        logic [7:0]        data_b;
        logic [7:0]        servo_index;
        logic [7:0]        test_action;
        logic [7:0]        zero_angle;
        logic signed [7:0] limit_low;
        logic signed [7:0] limit_high;
        logic              diverge_left;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [3:0]  channel;
        logic [11:0] pulse_tick;
        logic        last;
    } t_out_item;

    // One servo table entry.
    typedef struct packed {
        logic [7:0]        zero;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic              left;
    } t_servo_entry;

    // A move issued by the sequencer to the pulse unit.
    typedef struct packed {
        logic              valid;
        logic [3:0]        channel;
        logic              off;
        logic signed [7:0] rel;
        logic [7:0]        zero;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
    } t_move;

    // A finished pulse from the pulse unit.
    typedef struct packed {
        logic        valid;
        logic [3:0]  channel;
        logic [11:0] tick;
    } t_pulse;

endpackage

### src/tsp_servo_table.sv
// Servo table: per-channel zero angle, relative limits and diverging side.
// Depends on tsp_pkg for the entry type and the reset values.
module tsp_servo_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [3:0]            i_wr_idx,
    input  tsp_pkg::t_servo_entry i_wr_entry,
    input  logic [3:0]            i_rd_idx,
    output tsp_pkg::t_servo_entry o_rd_entry
);

    tsp_pkg::t_servo_entry r_entry [tsp_pkg::NUM_SLOTS];

    // Entries reset to the centred default and are written one at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsp_pkg::NUM_SLOTS; i++) begin
                r_entry[i].zero <= tsp_pkg::ZERO_RST;
                r_entry[i].lo   <= tsp_pkg::LO_RST;
                r_entry[i].hi   <= tsp_pkg::HI_RST;
                r_entry[i].left <= 1'b1;
            end
        end else if (i_wr_en) begin
            r_entry[i_wr_idx] <= i_wr_entry;
        end
    end

    // One read port for the channel the sequencer is working on.
    assign o_rd_entry = r_entry[i_rd_idx];

endmodule

### src/tsp_pulse_unit.sv
// Shared pulse unit: clamps a relative angle, adds zero and scales it to a PWM tick.
// Four stages that all advance together on i_adv. Depends on tsp_pkg.
module tsp_pulse_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  tsp_pkg::t_move i_move,
    input  logic [11:0]    i_min_tick,
    input  logic [11:0]    i_max_tick,
    output tsp_pkg::t_pulse o_result,
    output logic           o_busy
);

    // Stage 1: the issued move.
    tsp_pkg::t_move r_s1;

    // Stage 2: physical angle and pulse span.
    logic               r_s2_v;
    logic [3:0]         r_s2_ch;
    logic               r_s2_off;
    logic [7:0]         r_s2_phys;
    logic signed [12:0] r_s2_span;

    // Stage 3: product magnitude and sign.
    logic               r_s3_v;
    logic [3:0]         r_s3_ch;
    logic               r_s3_off;
    logic               r_s3_neg;
    logic [19:0]        r_s3_mag;

    // Stage 4: quotient magnitude and sign.
    logic               r_s4_v;
    logic [3:0]         r_s4_ch;
    logic               r_s4_off;
    logic               r_s4_neg;
    logic [11:0]        r_s4_quot;

    logic signed [7:0]  w_r1;
    logic signed [7:0]  w_r2;
    logic signed [7:0]  w_r3;
    logic signed [9:0]  w_phys_s;
    logic [7:0]         w_phys;
    logic signed [12:0] w_span;
    logic signed [21:0] w_prod;
    logic signed [21:0] w_prod_abs;
    logic [40:0]        w_scaled;
    logic signed [12:0] w_quot_s;
    logic signed [12:0] w_tick_s;

    // Clamp to the mechanical range, then to the entry limits (high limit wins).
    always_comb begin
        if (r_s1.rel < tsp_pkg::REL_MIN) begin
            w_r1 = tsp_pkg::REL_MIN;
        end else if (r_s1.rel > tsp_pkg::REL_MAX) begin
            w_r1 = tsp_pkg::REL_MAX;
        end else begin
            w_r1 = r_s1.rel;
        end
        w_r2 = (w_r1 < r_s1.lo) ? r_s1.lo : w_r1;
        w_r3 = (w_r2 > r_s1.hi) ? r_s1.hi : w_r2;
        w_phys_s = $signed({2'b00, r_s1.zero}) + $signed({{2{w_r3[7]}}, w_r3});
        if (w_phys_s < 10'sd0) begin
            w_phys = 8'd0;
        end else if (w_phys_s > $signed({2'b00, tsp_pkg::ANGLE_MAX})) begin
            w_phys = tsp_pkg::ANGLE_MAX;
        end else begin
            w_phys = w_phys_s[7:0];
        end
        w_span = $signed({1'b0, i_max_tick}) - $signed({1'b0, i_min_tick});
    end

    // Angle times span, split into sign and magnitude; both operands are widened first.
    assign w_prod     = $signed({13'd0, r_s2_phys}) * $signed({{9{r_s2_span[12]}}, r_s2_span});
    assign w_prod_abs = w_prod[21] ? -w_prod : w_prod;

    // Magnitude divided by 180 through the reciprocal.
    assign w_scaled = 41'(r_s3_mag) * 41'(tsp_pkg::RECIP_MULT);

    // Restore the sign (truncation toward zero) and add the minimum tick.
    assign w_quot_s = r_s4_neg ? -$signed({1'b0, r_s4_quot}) : $signed({1'b0, r_s4_quot});
    assign w_tick_s = w_quot_s + $signed({1'b0, i_min_tick});

    // Stage registers: valid bits are cleared by reset, the payload just follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_s4_v     <= 1'b0;
        end else if (i_adv) begin
            r_s1.valid   <= i_move.valid;
            r_s2_v       <= r_s1.valid;
            r_s3_v       <= r_s2_v;
            r_s4_v       <= r_s3_v;
            r_s1.channel <= i_move.channel;
            r_s1.off     <= i_move.off;
            r_s1.rel     <= i_move.rel;
            r_s1.zero    <= i_move.zero;
            r_s1.lo      <= i_move.lo;
            r_s1.hi      <= i_move.hi;
            r_s2_ch      <= r_s1.channel;
            r_s2_off     <= r_s1.off;
            r_s2_phys    <= w_phys;
            r_s2_span    <= w_span;
            r_s3_ch      <= r_s2_ch;
            r_s3_off     <= r_s2_off;
            r_s3_neg     <= w_prod[21];
            r_s3_mag     <= w_prod_abs[19:0];
            r_s4_ch      <= r_s3_ch;
            r_s4_off     <= r_s3_off;
            r_s4_neg     <= r_s3_neg;
            r_s4_quot    <= w_scaled[tsp_pkg::RECIP_SHIFT +: 12];
        end
    end

    assign o_result.valid   = r_s4_v;
    assign o_result.channel = r_s4_ch;
    assign o_result.tick    = r_s4_off ? 12'd0 : w_tick_s[11:0];
    assign o_busy           = r_s1.valid | r_s2_v | r_s3_v | r_s4_v;

endmodule

### src/turnout_servo_position_decoder.sv
// A pulse reaches the output register through the pulse unit stages and the hold stage.
// A tick with relaxing on or a changed bus update takes 16 steps, startup 32 and a valid
// test move 1, each then a drain; other items take no steps. Ready is low meanwhile;
// unless the output stalls, the sequencer steps one channel a cycle through the pulse unit.
// Output stalls freeze the pulse unit. Reset (synchronous, active low) restores the
// table, configuration and stored bytes and clears all countdowns and results.
module turnout_servo_position_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tsp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsp_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration registers.
    logic        r_use_a;
    logic        r_use_b;
    logic        r_relax_en;
    logic [15:0] r_relax_ticks;
    logic [11:0] r_min_tick;
    logic [11:0] r_max_tick;

    // Sequencer state.
    logic [1:0]  r_state,     n_state;
    logic [2:0]  r_mode,      n_mode;
    logic [4:0]  r_step,      n_step;
    logic [4:0]  r_last_step, n_last_step;
    logic [15:0] r_bits,      n_bits;
    logic [3:0]  r_test_ch,   n_test_ch;
    logic        r_test_bit,  n_test_bit;
    logic        r_test_ctr,  n_test_ctr;
    logic [7:0]  r_prev_a,    n_prev_a;
    logic [7:0]  r_prev_b,    n_prev_b;

    // Per-channel relax bookkeeping.
    logic [15:0] r_relax_cnt [tsp_pkg::NUM_SLOTS];
    logic        r_active    [tsp_pkg::NUM_SLOTS];

    // Hold stage and output register.
    logic        r_hold_v,   n_hold_v;
    logic [3:0]  r_hold_ch,  n_hold_ch;
    logic [11:0] r_hold_tick, n_hold_tick;
    logic        r_out_v,    n_out_v;
    tsp_pkg::t_out_item r_out, n_out;

    logic                  w_accept;
    logic                  w_adv;
    logic                  w_busy;
    logic                  w_idx_ok;
    logic                  w_act_ok;
    logic                  w_changed;
    logic                  w_tbl_wr;
    logic [3:0]            w_ch;
    logic                  w_ch_ok;
    logic                  w_bit;
    logic                  w_centre;
    logic                  w_group_en;
    logic                  w_en;
    logic                  w_off;
    logic                  w_tick_dec;
    logic                  w_step_go;
    logic                  w_finalize;
    logic [15:0]           w_cnt;
    logic [15:0]           w_load;
    tsp_pkg::t_servo_entry w_entry;
    tsp_pkg::t_servo_entry w_wr_entry;
    tsp_pkg::t_move        w_move;
    tsp_pkg::t_pulse       w_pulse;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_adv       = !r_out_v || i_out_ready;

    // Decode of the accepted item.
    assign w_idx_ok  = (i_in_item.servo_index < 8'(tsp_pkg::SERVO_CHANNELS));
    assign w_act_ok  = (i_in_item.test_action == tsp_pkg::ACT_CENTRE)
                    || (i_in_item.test_action == tsp_pkg::ACT_STRAIGHT)
                    || (i_in_item.test_action == tsp_pkg::ACT_DIVERGE);
    assign w_changed = (r_use_a && (i_in_item.data_a != r_prev_a))
                    || (r_use_b && (i_in_item.data_b != r_prev_b));
    assign w_tbl_wr  = w_accept && (i_in_item.command == tsp_pkg::CMD_WRITE) && w_idx_ok;

    assign w_wr_entry.zero = i_in_item.zero_angle;
    assign w_wr_entry.lo   = i_in_item.limit_low;
    assign w_wr_entry.hi   = i_in_item.limit_high;
    assign w_wr_entry.left = i_in_item.diverge_left;

    tsp_servo_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_tbl_wr),
        .i_wr_idx   (i_in_item.servo_index[3:0]),
        .i_wr_entry (w_wr_entry),
        .i_rd_idx   (w_ch),
        .o_rd_entry (w_entry)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_a       <= 1'b1;
            r_use_b       <= 1'b1;
            r_relax_en    <= 1'b1;
            r_relax_ticks <= tsp_pkg::RELAX_TICKS_RST;
            r_min_tick    <= tsp_pkg::MIN_PULSE_RST;
            r_max_tick    <= tsp_pkg::MAX_PULSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tsp_pkg::CFG_USE_GROUP_A:  r_use_a       <= i_cfg_data[0];
                tsp_pkg::CFG_USE_GROUP_B:  r_use_b       <= i_cfg_data[0];
                tsp_pkg::CFG_RELAX_ENABLE: r_relax_en    <= i_cfg_data[0];
                tsp_pkg::CFG_RELAX_TICKS:  r_relax_ticks <= i_cfg_data;
                tsp_pkg::CFG_MIN_PULSE:    r_min_tick    <= i_cfg_data[11:0];
                tsp_pkg::CFG_MAX_PULSE:    r_max_tick    <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Channel and target of the current step.
    always_comb begin
        w_ch       = (r_mode == tsp_pkg::CMD_TEST) ? r_test_ch : r_step[3:0];
        w_ch_ok    = ({1'b0, w_ch} < 5'(tsp_pkg::SERVO_CHANNELS));
        w_bit      = (r_mode == tsp_pkg::CMD_TEST) ? r_test_bit : r_bits[w_ch];
        w_centre   = ((r_mode == tsp_pkg::CMD_TEST) && r_test_ctr)
                  || ((r_mode == tsp_pkg::CMD_STARTUP) && !r_step[4]);
        w_group_en = w_ch[3] ? r_use_b : r_use_a;
        w_cnt      = r_relax_cnt[w_ch];
        w_off      = 1'b0;
        w_en       = 1'b0;
        w_tick_dec = 1'b0;
        unique case (r_mode)
            tsp_pkg::CMD_TICK: begin
                w_tick_dec = w_ch_ok && r_active[w_ch] && (w_cnt != 16'd0);
                w_en       = w_tick_dec && (w_cnt == 16'd1);
                w_off      = 1'b1;
            end
            tsp_pkg::CMD_BUS:     w_en = w_ch_ok && w_group_en;
            tsp_pkg::CMD_TEST:    w_en = w_ch_ok;
            tsp_pkg::CMD_STARTUP: w_en = w_ch_ok && (!r_step[4] || w_group_en);
            default: begin
            end
        endcase
    end

    // Move handed to the pulse unit.
    always_comb begin
        w_move.valid   = (r_state == ST_RUN) && w_en;
        w_move.channel = w_ch;
        w_move.off     = w_off;
        w_move.zero    = w_entry.zero;
        w_move.lo      = w_entry.lo;
        w_move.hi      = w_entry.hi;
        if (w_centre) begin
            w_move.rel = 8'sd0;
        end else if (w_bit) begin
            w_move.rel = w_entry.left ? w_entry.lo : w_entry.hi;
        end else begin
            w_move.rel = w_entry.left ? w_entry.hi : w_entry.lo;
        end
    end

    tsp_pulse_unit u_pulse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_move     (w_move),
        .i_min_tick (r_min_tick),
        .i_max_tick (r_max_tick),
        .o_result   (w_pulse),
        .o_busy     (w_busy)
    );

    assign w_step_go  = (r_state == ST_RUN) && w_adv;
    assign w_finalize = (r_state == ST_DRAIN) && !w_busy && w_adv && r_hold_v;
    assign w_load     = r_relax_en ? ((r_relax_ticks == 16'd0) ? 16'd1 : r_relax_ticks)
                                   : 16'd0;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_step      = r_step;
        n_last_step = r_last_step;
        n_bits      = r_bits;
        n_test_ch   = r_test_ch;
        n_test_bit  = r_test_bit;
        n_test_ctr  = r_test_ctr;
        n_prev_a    = r_prev_a;
        n_prev_b    = r_prev_b;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode = i_in_item.command;
                    n_step = 5'd0;
                    case (i_in_item.command)
                        tsp_pkg::CMD_TICK: begin
                            if (r_relax_en) begin
                                n_state     = ST_RUN;
                                n_last_step = 5'd15;
                            end
                        end
                        tsp_pkg::CMD_BUS: begin
                            if (w_changed) begin
                                n_state     = ST_RUN;
                                n_last_step = 5'd15;
                                n_bits      = {i_in_item.data_b, i_in_item.data_a};
                                if (r_use_a) begin
                                    n_prev_a = i_in_item.data_a;
                                end
                                if (r_use_b) begin
                                    n_prev_b = i_in_item.data_b;
                                end
                            end
                        end
                        tsp_pkg::CMD_TEST: begin
                            if (w_idx_ok && w_act_ok) begin
                                n_state     = ST_RUN;
                                n_last_step = 5'd0;
                                n_test_ch   = i_in_item.servo_index[3:0];
                                n_test_ctr  = (i_in_item.test_action == tsp_pkg::ACT_CENTRE);
                                n_test_bit  = (i_in_item.test_action == tsp_pkg::ACT_DIVERGE);
                            end
                        end
                        tsp_pkg::CMD_STARTUP: begin
                            n_state     = ST_RUN;
                            n_last_step = 5'd31;
                            n_prev_a    = r_use_a ? i_in_item.data_a : 8'd0;
                            n_prev_b    = r_use_b ? i_in_item.data_b : 8'd0;
                            n_bits      = {n_prev_b, n_prev_a};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    if (r_step == r_last_step) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!w_busy && w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold stage keeps the newest pulse back until it is known whether it is the last.
    always_comb begin
        n_hold_v    = r_hold_v;
        n_hold_ch   = r_hold_ch;
        n_hold_tick = r_hold_tick;
        n_out_v     = r_out_v && !i_out_ready;
        n_out       = r_out;
        if (w_adv && w_pulse.valid) begin
            if (r_hold_v) begin
                n_out_v            = 1'b1;
                n_out.channel      = r_hold_ch;
                n_out.pulse_tick   = r_hold_tick;
                n_out.last         = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_ch   = w_pulse.channel;
            n_hold_tick = w_pulse.tick;
        end else if (w_finalize) begin
            n_out_v          = 1'b1;
            n_out.channel    = r_hold_ch;
            n_out.pulse_tick = r_hold_tick;
            n_out.last       = 1'b1;
            n_hold_v         = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev_a <= 8'hFF;
            r_prev_b <= 8'hFF;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev_a <= n_prev_a;
            r_prev_b <= n_prev_b;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_step      <= n_step;
        r_last_step <= n_last_step;
        r_bits      <= n_bits;
        r_test_ch   <= n_test_ch;
        r_test_bit  <= n_test_bit;
        r_test_ctr  <= n_test_ctr;
        r_hold_ch   <= n_hold_ch;
        r_hold_tick <= n_hold_tick;
        r_out       <= n_out;
    end

    // Relax countdowns: loaded on a move, counted down by ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsp_pkg::NUM_SLOTS; i++) begin
                r_relax_cnt[i] <= 16'd0;
                r_active[i]    <= 1'b0;
            end
        end else if (w_step_go) begin
            if (w_tick_dec) begin
                r_relax_cnt[w_ch] <= w_cnt - 16'd1;
                if (w_cnt == 16'd1) begin
                    r_active[w_ch] <= 1'b0;
                end
            end else if (w_en) begin
                r_relax_cnt[w_ch] <= w_load;
                r_active[w_ch]    <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

### src/tsp_checker.sv
// Port-level checker for the turnout servo position decoder, bound to the top level.
// Depends on tsp_pkg for the command codes and the channel count.
module tsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input tsp_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input tsp_pkg::t_out_item o_out_item
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // Results only address channels that exist.
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_item.channel} < 5'(tsp_pkg::SERVO_CHANNELS)))
        else $error("result item for a channel out of range");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result pending or busy after reset");

    // A table write finishes at once.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.command == tsp_pkg::CMD_WRITE) |=> o_in_ready)
        else $error("table write kept the block busy");

endmodule

bind turnout_servo_position_decoder tsp_checker u_tsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

### tb/sv/turnout_servo_position_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the turnout servo position decoder.
// Depends on tsp_pkg and turnout_servo_position_decoder; the scoreboard class lives here too.

// Predicts the pulse items of the decoder and checks them in order.
class pulse_scoreboard;

    tsp_pkg::t_servo_entry entries [16];
    logic [7:0]            bus_seen_a;
    logic [7:0]            bus_seen_b;
    logic [15:0]           relax_left [16];
    bit                    powered [16];

    bit                    follow_a;
    bit                    follow_b;
    bit                    relax_on;
    logic [15:0]           relax_len;
    logic [11:0]           tick_at_0;
    logic [11:0]           tick_at_180;

    tsp_pkg::t_out_item    pending_pulses [$];
    int                    mismatches;
    int                    items_taken;
    int                    pulses_checked;

    // State right after reset.
    function new();
        for (int i = 0; i < 16; i++) begin
            entries[i].zero = tsp_pkg::ZERO_RST;
            entries[i].lo   = tsp_pkg::LO_RST;
            entries[i].hi   = tsp_pkg::HI_RST;
            entries[i].left = 1'b1;
            relax_left[i]   = '0;
            powered[i]      = 1'b0;
        end
        bus_seen_a  = 8'hFF;
        bus_seen_b  = 8'hFF;
        follow_a    = 1'b1;
        follow_b    = 1'b1;
        relax_on    = 1'b1;
        relax_len   = tsp_pkg::RELAX_TICKS_RST;
        tick_at_0   = tsp_pkg::MIN_PULSE_RST;
        tick_at_180 = tsp_pkg::MAX_PULSE_RST;
        mismatches  = 0;
        items_taken = 0;
        pulses_checked = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [15:0] data);
        case (index)
            tsp_pkg::CFG_USE_GROUP_A:  follow_a    = data[0];
            tsp_pkg::CFG_USE_GROUP_B:  follow_b    = data[0];
            tsp_pkg::CFG_RELAX_ENABLE: relax_on    = data[0];
            tsp_pkg::CFG_RELAX_TICKS:  relax_len   = data;
            tsp_pkg::CFG_MIN_PULSE:    tick_at_0   = data[11:0];
            tsp_pkg::CFG_MAX_PULSE:    tick_at_180 = data[11:0];
            default: ;
        endcase
    endfunction

    function void add_pulse(int ch, logic [11:0] tick);
        tsp_pkg::t_out_item p;
        p.channel    = ch[3:0];
        p.pulse_tick = tick;
        p.last       = 1'b0;
        pending_pulses.push_back(p);
    endfunction

    // Clamp the relative angle, offset by zero, clamp again and scale to a tick.
    function void drive_servo(int ch, int rel);
        int r;
        int lo;
        int hi;
        int phys;
        int span;
        int tick;
        if (ch >= tsp_pkg::SERVO_CHANNELS || ch >= 16) return;
        lo = int'($signed(entries[ch].lo));
        hi = int'($signed(entries[ch].hi));
        r  = rel;
        if (r < int'(tsp_pkg::REL_MIN)) r = int'(tsp_pkg::REL_MIN);
        if (r > int'(tsp_pkg::REL_MAX)) r = int'(tsp_pkg::REL_MAX);
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        phys = int'(entries[ch].zero) + r;
        if (phys < 0) phys = 0;
        if (phys > int'(tsp_pkg::ANGLE_MAX)) phys = int'(tsp_pkg::ANGLE_MAX);
        span = int'(tick_at_180) - int'(tick_at_0);
        tick = phys * span / int'(tsp_pkg::ANGLE_MAX) + int'(tick_at_0);
        add_pulse(ch, tick[11:0]);
        powered[ch] = 1'b1;
        if (relax_on)
            relax_left[ch] = (relax_len == 16'd0) ? 16'd1 : relax_len;
        else
            relax_left[ch] = 16'd0;
    endfunction

    // A set bit means the diverging end, whose side the entry chooses.
    function void drive_to_end(int ch, bit diverging);
        int lo;
        int hi;
        if (ch >= tsp_pkg::SERVO_CHANNELS || ch >= 16) return;
        lo = int'($signed(entries[ch].lo));
        hi = int'($signed(entries[ch].hi));
        if (diverging)
            drive_servo(ch, entries[ch].left ? lo : hi);
        else
            drive_servo(ch, entries[ch].left ? hi : lo);
    endfunction

    function void follow_bus(logic [7:0] a, logic [7:0] b);
        if (follow_a)
            for (int i = 0; i < 8; i++) drive_to_end(i, a[i]);
        if (follow_b)
            for (int i = 0; i < 8; i++) drive_to_end(i + 8, b[i]);
    endfunction

    // Work out every pulse item that one accepted input item causes.
    function void take_command(tsp_pkg::t_in_item it);
        int first;
        int idx;
        tsp_pkg::t_out_item tail;
        first = pending_pulses.size();
        idx   = int'(it.servo_index);
        items_taken++;
        case (it.command)
            tsp_pkg::CMD_TICK: begin
                if (relax_on) begin
                    for (int i = 0; i < tsp_pkg::SERVO_CHANNELS && i < 16; i++) begin
                        if (powered[i] && relax_left[i] != 16'd0) begin
                            relax_left[i]--;
                            if (relax_left[i] == 16'd0) begin
                                powered[i] = 1'b0;
                                add_pulse(i, 12'd0);
                            end
                        end
                    end
                end
            end
            tsp_pkg::CMD_BUS: begin
                if ((follow_a && it.data_a != bus_seen_a) ||
                    (follow_b && it.data_b != bus_seen_b)) begin
                    follow_bus(it.data_a, it.data_b);
                    if (follow_a) bus_seen_a = it.data_a;
                    if (follow_b) bus_seen_b = it.data_b;
                end
            end
            tsp_pkg::CMD_TEST: begin
                if (idx < tsp_pkg::SERVO_CHANNELS) begin
                    if (it.test_action == tsp_pkg::ACT_CENTRE) drive_servo(idx, 0);
                    else if (it.test_action == tsp_pkg::ACT_STRAIGHT) drive_to_end(idx, 1'b0);
                    else if (it.test_action == tsp_pkg::ACT_DIVERGE) drive_to_end(idx, 1'b1);
                end
            end
            tsp_pkg::CMD_WRITE: begin
                if (idx < tsp_pkg::SERVO_CHANNELS && idx < 16) begin
                    entries[idx].zero = it.zero_angle;
                    entries[idx].lo   = it.limit_low;
                    entries[idx].hi   = it.limit_high;
                    entries[idx].left = it.diverge_left;
                end
            end
            tsp_pkg::CMD_STARTUP: begin
                for (int i = 0; i < tsp_pkg::SERVO_CHANNELS && i < 16; i++) drive_servo(i, 0);
                bus_seen_a = follow_a ? it.data_a : 8'h00;
                bus_seen_b = follow_b ? it.data_b : 8'h00;
                follow_bus(bus_seen_a, bus_seen_b);
            end
            default: ;
        endcase
        if (pending_pulses.size() > first) begin
            tail = pending_pulses.pop_back();
            tail.last = 1'b1;
            pending_pulses.push_back(tail);
        end
    endfunction

    function void check_pulse(tsp_pkg::t_out_item got);
        tsp_pkg::t_out_item want;
        pulses_checked++;
        if (pending_pulses.size() == 0) begin
            mismatches++;
            $error("unexpected item: channel %0d pulse_tick %0d last %0d",
                   got.channel, got.pulse_tick, got.last);
            return;
        end
        want = pending_pulses.pop_front();
        if (got.channel !== want.channel) begin
            mismatches++;
            $error("channel: expected %0d, actual %0d", want.channel, got.channel);
        end
        if (got.pulse_tick !== want.pulse_tick) begin
            mismatches++;
            $error("pulse_tick: expected %0d, actual %0d", want.pulse_tick, got.pulse_tick);
        end
        if (got.last !== want.last) begin
            mismatches++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
        end
    endfunction

endclass

module turnout_servo_position_decoder_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 60;
    localparam int PHASE_ITEMS  = 32;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    tsp_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    tsp_pkg::t_out_item o_out_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    pulse_scoreboard sb = new();

    bit          calm;
    int          cycles;
    int          settings_used;
    logic [7:0]  bus_a;
    logic [7:0]  bus_b;

    turnout_servo_position_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 12 ns period.
    always #6 i_clk = ~i_clk;

    // Watch all three handshakes on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.take_command(i_in_item);
            if (o_out_valid && i_out_ready) sb.check_pulse(o_out_item);
        end
    end

    // The receiver stalls now and then, except in calm stretches.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 16);
    end

    // Stop a run that hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("turnout_servo_position_decoder_test: errors");
            $finish;
        end
    end

    // Every field gets random bits, so unused fields toggle as well.
    function automatic tsp_pkg::t_in_item scrambled_item();
        tsp_pkg::t_in_item it;
        it.command      = 3'($urandom);
        it.data_a       = 8'($urandom);
        it.data_b       = 8'($urandom);
        it.servo_index  = 8'($urandom);
        it.test_action  = 8'($urandom);
        it.zero_angle   = 8'($urandom);
        it.limit_low    = 8'($urandom);
        it.limit_high   = 8'($urandom);
        it.diverge_left = 1'($urandom);
        return it;
    endfunction

    // Mostly well-formed commands with random content, plus some noise.
    function automatic tsp_pkg::t_in_item random_item();
        tsp_pkg::t_in_item it;
        int pick;
        it   = scrambled_item();
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.command = tsp_pkg::CMD_TICK;
        end else if (pick < 55) begin
            it.command = tsp_pkg::CMD_BUS;
            if ($urandom_range(3) == 0) begin
                it.data_a = bus_a;
                it.data_b = bus_b;
            end else if ($urandom_range(2) == 0) begin
                it.data_a = bus_a ^ (8'd1 << $urandom_range(7));
                it.data_b = bus_b;
            end
            bus_a = it.data_a;
            bus_b = it.data_b;
        end else if (pick < 72) begin
            it.command = tsp_pkg::CMD_TEST;
            if ($urandom_range(7) != 0) it.servo_index = 8'($urandom_range(15));
            if ($urandom_range(7) != 0) it.test_action = 8'($urandom_range(2, 4));
        end else if (pick < 85) begin
            it.command = tsp_pkg::CMD_WRITE;
            if ($urandom_range(7) != 0) it.servo_index = 8'($urandom_range(15));
            if ($urandom_range(9) != 0) begin
                it.zero_angle = 8'($urandom_range(180));
                it.limit_low  = 8'($signed($urandom_range(180)) - 90);
                it.limit_high = 8'($signed($urandom_range(180)) - 90);
            end
        end else if (pick < 90) begin
            it.command = tsp_pkg::CMD_STARTUP;
            bus_a = it.data_a;
            bus_b = it.data_b;
        end else if (pick < 95) begin
            it.command = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    // Offer one item, now and then after a random gap, and hold it until it is taken.
    task automatic send_item(input tsp_pkg::t_in_item it);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] idx, input logic [7:0] act);
        tsp_pkg::t_in_item it;
        it             = scrambled_item();
        it.command     = cmd;
        it.data_a      = a;
        it.data_b      = b;
        it.servo_index = idx;
        it.test_action = act;
        send_item(it);
    endtask

    task automatic send_entry(input logic [7:0] idx, input logic [7:0] zero,
                              input logic signed [7:0] lo, input logic signed [7:0] hi,
                              input logic left);
        tsp_pkg::t_in_item it;
        it              = scrambled_item();
        it.command      = tsp_pkg::CMD_WRITE;
        it.servo_index  = idx;
        it.zero_angle   = zero;
        it.limit_low    = lo;
        it.limit_high   = hi;
        it.diverge_left = left;
        send_item(it);
    endtask

    // Drop valid, wait until every predicted item has arrived, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_pulses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input bit ga, input bit gb, input bit relax,
                                 input logic [15:0] ticks, input logic [11:0] lo_tick,
                                 input logic [11:0] hi_tick);
        write_reg(tsp_pkg::CFG_USE_GROUP_A, {15'd0, ga});
        write_reg(tsp_pkg::CFG_USE_GROUP_B, {15'd0, gb});
        write_reg(tsp_pkg::CFG_RELAX_ENABLE, {15'd0, relax});
        write_reg(tsp_pkg::CFG_RELAX_TICKS, ticks);
        write_reg(tsp_pkg::CFG_MIN_PULSE, {4'd0, lo_tick});
        write_reg(tsp_pkg::CFG_MAX_PULSE, {4'd0, hi_tick});
        settings_used++;
    endtask

    task automatic random_phase(input int count, input bit pause_midway);
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) drain();
            send_item(random_item());
        end
        drain();
    endtask

    initial begin
        logic [11:0] lo_tick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        cycles      = 0;
        settings_used = 1;
        bus_a       = 8'hFF;
        bus_b       = 8'hFF;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration.
        send_cmd(tsp_pkg::CMD_STARTUP, 8'hA5, 8'h3C, 8'd0, 8'd0);
        send_cmd(tsp_pkg::CMD_BUS, 8'hA5, 8'h3C, 8'd0, 8'd0);
        send_cmd(tsp_pkg::CMD_BUS, 8'h00, 8'hFF, 8'd0, 8'd0);
        // Full-range limits, inverted limits, an out-of-range zero angle and servo index.
        send_entry(8'd0, 8'd0, -8'sd90, 8'sd90, 1'b0);
        send_entry(8'd1, 8'd180, 8'sd50, -8'sd50, 1'b1);
        send_entry(8'd2, 8'd255, -8'sd128, 8'sd127, 1'b0);
        send_entry(8'd255, 8'd0, 8'sd0, 8'sd0, 1'b0);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd0, tsp_pkg::ACT_STRAIGHT);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd0, tsp_pkg::ACT_DIVERGE);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd1, tsp_pkg::ACT_DIVERGE);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd2, tsp_pkg::ACT_STRAIGHT);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd2, tsp_pkg::ACT_DIVERGE);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd15, tsp_pkg::ACT_CENTRE);
        // Servo out of range and unknown actions cause nothing.
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd16, tsp_pkg::ACT_DIVERGE);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd3, 8'd0);
        send_cmd(tsp_pkg::CMD_TEST, 8'h00, 8'h00, 8'd3, 8'd255);
        send_cmd(tsp_pkg::CMD_BUS, 8'hFF, 8'h00, 8'd0, 8'd0);
        // Unknown commands.
        send_cmd(3'd5, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(3'd6, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(3'd7, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(tsp_pkg::CMD_TICK, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(tsp_pkg::CMD_TICK, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(tsp_pkg::CMD_STARTUP, 8'h00, 8'hFF, 8'd0, 8'd0);
        bus_a = 8'h00;
        bus_b = 8'hFF;
        drain();

        // Random phases, each under its own setting.
        apply_setting(1'b1, 1'b1, 1'b1, 16'd3, 12'd110, 12'd500);
        random_phase(PHASE_ITEMS, 1'b0);

        // Widest pulse range and the shortest relax time; the sender pauses once.
        apply_setting(1'b1, 1'b0, 1'b1, 16'd1, 12'd0, 12'd4095);
        random_phase(PHASE_ITEMS, 1'b1);

        // Inverted pulse range with relaxing off.
        apply_setting(1'b0, 1'b1, 1'b0, 16'd65535, 12'd4095, 12'd0);
        random_phase(PHASE_ITEMS, 1'b0);

        // No group follows the bus; neither side idles here.
        calm = 1'b1;
        apply_setting(1'b0, 1'b0, 1'b1, 16'd2, 12'd200, 12'd300);
        random_phase(PHASE_ITEMS, 1'b0);
        calm = 1'b0;

        lo_tick = 12'($urandom_range(2047));
        apply_setting(1'b1, 1'b1, 1'b1, 16'd5, lo_tick, 12'($urandom_range(lo_tick, 4095)));
        random_phase(PHASE_ITEMS, 1'b0);

        $display("Summary: %0d input items and %0d pulse items checked under %0d settings,",
                 sb.items_taken, sb.pulses_checked, settings_used);
        $display("  with %0d mismatches, in %0d cycles.", sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending_pulses.size() == 0)
            $display("turnout_servo_position_decoder_test: clean");
        else
            $display("turnout_servo_position_decoder_test: errors");
        $finish;
    end

endmodule
